@@ hdl/wsp_pkg.sv @@
// Package for the wheel speed regulator: item kinds, register indexes,
// stage payload types and the field widths fixed by the item format.
// No dependencies.
package wsp_pkg;

  // Field widths
  localparam int COUNT_W  = 16;
  localparam int TGT_W    = 16;
  localparam int SUM_W    = 22;
  localparam int ERR_W    = 23;
  localparam int INTEG_W  = 21;
  localparam int DERIV_W  = 28;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 20;
  localparam int DRV_CFG_W = 14;
  localparam int DRIVE_W  = 15;
  localparam int DUTY_W   = 14;
  localparam int CMD_W    = 16;
  localparam int ACC_W    = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  // Product widths (unsigned gain widened by one sign bit)
  localparam int PROD_FF_W = GAIN_W + 1 + TGT_W;
  localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W  = GAIN_W + 1 + INTEG_W;
  localparam int PROD_D_W  = GAIN_W + 1 + DERIV_W;

  localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sd32767;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FF_GAIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_WIN   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_LIMIT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SLEW_LIMIT  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_LIMIT = 3'd7;

  // What the drive stage does with an item
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_UPDATE = 2'd2
  } wsp_op_t;

  typedef struct packed {
    logic [GAIN_W-1:0]    prop_gain;
    logic [GAIN_W-1:0]    integ_gain;
    logic [GAIN_W-1:0]    deriv_gain;
    logic [GAIN_W-1:0]    ff_gain;
    logic [GAIN_W-1:0]    integ_window;
    logic [LIMIT_W-1:0]   integ_limit;
    logic [DRV_CFG_W-1:0] slew_limit;
    logic [DRV_CFG_W-1:0] drive_limit;
  } wsp_cfg_t;

  // Stage load strobes
  typedef struct packed {
    logic take_a;
    logic take_b;
    logic take_c;
    logic take_d;
  } wsp_pipe_t;

  // Status carried alongside the arithmetic
  typedef struct packed {
    wsp_op_t                   op;
    logic                      updated;
    logic signed [COUNT_W-1:0] delta;
    logic signed [SUM_W-1:0]   wsum;
  } wsp_tag_t;

  typedef struct packed {
    wsp_tag_t                  tag;
    logic signed [TGT_W-1:0]   target;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } wsp_front_t;

  typedef struct packed {
    wsp_tag_t                    tag;
    logic signed [PROD_FF_W-1:0] p_ff;
    logic signed [PROD_P_W-1:0]  p_p;
    logic signed [PROD_I_W-1:0]  p_i;
    logic signed [PROD_D_W-1:0]  p_d;
  } wsp_prod_t;

  typedef struct packed {
    wsp_tag_t                tag;
    logic signed [CMD_W-1:0] cmd;
  } wsp_cmd_t;

endpackage

@@ hdl/wsp_if.sv @@
// Valid/ready channel interfaces for sample/target items and results.
// Depends on wsp_pkg for field widths.
interface wsp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [wsp_pkg::COUNT_W-1:0]         encoder_count;
  logic signed [wsp_pkg::TGT_W-1:0]    target_value;

  modport source (output valid, kind, encoder_count, target_value, input ready);
  modport sink   (input valid, kind, encoder_count, target_value, output ready);
endinterface

interface wsp_out_if;
  logic                                valid;
  logic                                ready;
  logic [wsp_pkg::DUTY_W-1:0]          drive_duty;
  logic                                drive_reverse;
  logic                                drive_updated;
  logic signed [wsp_pkg::COUNT_W-1:0]  sample_delta;
  logic signed [wsp_pkg::SUM_W-1:0]    window_pulses;

  modport source (output valid, drive_duty, drive_reverse, drive_updated, sample_delta,
                  window_pulses, input ready);
  modport sink   (input valid, drive_duty, drive_reverse, drive_updated, sample_delta,
                  window_pulses, output ready);
endinterface

@@ hdl/wsp_front.sv @@
// Front stage: encoder delta, window sum, error, clamped integral and
// derivative term. Holds the loop state that items update in order.
// Depends on wsp_pkg.
module wsp_front #(
  parameter int WINDOW_SAMPLES = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic                              kind,
  input  logic [wsp_pkg::COUNT_W-1:0]       encoder_count,
  input  logic signed [wsp_pkg::TGT_W-1:0]  target_value,
  input  wsp_pkg::wsp_cfg_t                 cfg,
  output wsp_pkg::wsp_front_t               front_r
);

  localparam int IDX_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SAMPLES - 1);

  // Loop state
  logic [wsp_pkg::COUNT_W-1:0]        prev_count_r, prev_count_nxt;
  logic                               first_r, first_nxt;
  logic signed [wsp_pkg::COUNT_W-1:0] latest_r, latest_nxt;
  logic signed [wsp_pkg::SUM_W-1:0]   psum_r, psum_nxt;
  logic signed [wsp_pkg::SUM_W-1:0]   lwsum_r, lwsum_nxt;
  logic [IDX_W-1:0]                   idx_r, idx_nxt;
  logic signed [wsp_pkg::INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [wsp_pkg::ERR_W-1:0]   perr_r, perr_nxt;
  logic signed [wsp_pkg::TGT_W-1:0]   target_r, target_nxt;

  // Arithmetic
  logic [wsp_pkg::COUNT_W-1:0]        d_raw;
  logic signed [wsp_pkg::COUNT_W-1:0] delta;
  logic signed [wsp_pkg::SUM_W-1:0]   psum_add;
  logic                               wend;
  logic signed [wsp_pkg::ERR_W-1:0]   err;
  logic [wsp_pkg::ERR_W-1:0]          err_mag;
  logic                               in_win;
  logic signed [23:0]                 isum;
  logic signed [23:0]                 ilim;
  logic signed [wsp_pkg::INTEG_W-1:0] integ_upd;
  logic signed [23:0]                 ediff;
  logic signed [wsp_pkg::DERIV_W-1:0] ediff_x;
  logic signed [wsp_pkg::DERIV_W-1:0] deriv;
  wsp_pkg::wsp_op_t                   op;

  // Delta, window sum and control terms
  always_comb begin
    d_raw    = encoder_count - prev_count_r;
    delta    = first_r ? '0 : $signed(d_raw);
    psum_add = psum_r + wsp_pkg::SUM_W'(delta);
    wend     = (idx_r == IDX_LAST);
    err      = wsp_pkg::ERR_W'(target_r) - wsp_pkg::ERR_W'(psum_add);
    err_mag  = err[wsp_pkg::ERR_W-1] ? wsp_pkg::ERR_W'(-err) : err;
    in_win   = err_mag < wsp_pkg::ERR_W'(cfg.integ_window);
    isum     = 24'(integ_r) + 24'(err);
    ilim     = $signed({4'b0, cfg.integ_limit});
    if (isum > ilim) begin
      integ_upd = wsp_pkg::INTEG_W'(ilim);
    end else if (isum < -ilim) begin
      integ_upd = wsp_pkg::INTEG_W'(-ilim);
    end else begin
      integ_upd = wsp_pkg::INTEG_W'(isum);
    end
    ediff   = 24'(err) - 24'(perr_r);
    ediff_x = wsp_pkg::DERIV_W'(ediff);
    // ten times the error change
    deriv   = (ediff_x <<< 3) + (ediff_x <<< 1);
  end

  // Next state for one item
  always_comb begin
    prev_count_nxt = prev_count_r;
    first_nxt      = first_r;
    latest_nxt     = latest_r;
    psum_nxt       = psum_r;
    lwsum_nxt      = lwsum_r;
    idx_nxt        = idx_r;
    integ_nxt      = integ_r;
    perr_nxt       = perr_r;
    target_nxt     = target_r;
    op             = wsp_pkg::OP_HOLD;
    if (kind == wsp_pkg::KIND_SAMPLE) begin
      first_nxt      = 1'b0;
      prev_count_nxt = encoder_count;
      if (wend) begin
        idx_nxt  = '0;
        psum_nxt = '0;
        if (target_r == '0) begin
          // zero target at window end clears the loop
          lwsum_nxt  = '0;
          latest_nxt = '0;
          integ_nxt  = '0;
          perr_nxt   = '0;
          op         = wsp_pkg::OP_CLEAR;
        end else begin
          lwsum_nxt  = psum_add;
          latest_nxt = delta;
          integ_nxt  = in_win ? integ_upd : integ_r;
          perr_nxt   = err;
          op         = wsp_pkg::OP_UPDATE;
        end
      end else begin
        idx_nxt    = idx_r + 1'b1;
        psum_nxt   = psum_add;
        latest_nxt = delta;
      end
    end else begin
      target_nxt = target_value;
      if (target_value == '0) begin
        integ_nxt = '0;
        perr_nxt  = '0;
        op        = wsp_pkg::OP_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
      first_r      <= 1'b1;
      latest_r     <= '0;
      psum_r       <= '0;
      lwsum_r      <= '0;
      idx_r        <= '0;
      integ_r      <= '0;
      perr_r       <= '0;
      target_r     <= '0;
    end else if (take) begin
      prev_count_r <= prev_count_nxt;
      first_r      <= first_nxt;
      latest_r     <= latest_nxt;
      psum_r       <= psum_nxt;
      lwsum_r      <= lwsum_nxt;
      idx_r        <= idx_nxt;
      integ_r      <= integ_nxt;
      perr_r       <= perr_nxt;
      target_r     <= target_nxt;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      front_r.tag.op      <= op;
      front_r.tag.updated <= (kind == wsp_pkg::KIND_SAMPLE) && wend;
      front_r.tag.delta   <= latest_nxt;
      front_r.tag.wsum    <= lwsum_nxt;
      front_r.target      <= target_nxt;
      front_r.err         <= err;
      front_r.integ       <= integ_nxt;
      front_r.deriv       <= deriv;
    end
  end

endmodule

@@ hdl/wsp_gain.sv @@
// Gain stages: four parallel gain multiplies, then the weighted sum scaled
// down by the gain fraction bits and saturated to the command range.
// Depends on wsp_pkg.
module wsp_gain #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  wsp_pkg::wsp_pipe_t   pipe,
  input  wsp_pkg::wsp_cfg_t    cfg,
  input  wsp_pkg::wsp_front_t  front_r,
  output wsp_pkg::wsp_cmd_t    cmd_r
);

  wsp_pkg::wsp_prod_t              prod_r;
  logic signed [wsp_pkg::ACC_W-1:0] sum;
  logic [wsp_pkg::ACC_W-1:0]       sum_mag;
  logic [wsp_pkg::ACC_W-1:0]       q;
  logic [wsp_pkg::CMD_W-1:0]       q_sat;
  logic signed [wsp_pkg::CMD_W-1:0] cmd;

  // Multiplies, one register after
  always_ff @(posedge clk) begin
    if (pipe.take_b) begin
      prod_r.tag  <= front_r.tag;
      prod_r.p_ff <= $signed({1'b0, cfg.ff_gain}) * front_r.target;
      prod_r.p_p  <= $signed({1'b0, cfg.prop_gain}) * front_r.err;
      prod_r.p_i  <= $signed({1'b0, cfg.integ_gain}) * front_r.integ;
      prod_r.p_d  <= $signed({1'b0, cfg.deriv_gain}) * front_r.deriv;
    end
  end

  // Sum, truncate toward zero, saturate
  always_comb begin
    sum = wsp_pkg::ACC_W'(prod_r.p_ff) + wsp_pkg::ACC_W'(prod_r.p_p)
        + wsp_pkg::ACC_W'(prod_r.p_i) + wsp_pkg::ACC_W'(prod_r.p_d);
    sum_mag = sum[wsp_pkg::ACC_W-1] ? wsp_pkg::ACC_W'(-sum) : wsp_pkg::ACC_W'(sum);
    q       = sum_mag >> GAIN_FRAC_BITS;
    q_sat   = (q > wsp_pkg::ACC_W'(wsp_pkg::CMD_MAX)) ? wsp_pkg::CMD_MAX
                                                       : q[wsp_pkg::CMD_W-1:0];
    cmd     = sum[wsp_pkg::ACC_W-1] ? -$signed(q_sat) : $signed(q_sat);
  end

  always_ff @(posedge clk) begin
    if (pipe.take_c) begin
      cmd_r.tag <= prod_r.tag;
      cmd_r.cmd <= cmd;
    end
  end

endmodule

@@ hdl/wsp_drive.sv @@
// Drive stage: slew limit toward the command, clamp to the drive limits,
// hold the drive state and the result register.
// Depends on wsp_pkg.
module wsp_drive #(
  parameter int DUTY_MAX = 10000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wsp_pkg::wsp_pipe_t                 pipe,
  input  wsp_pkg::wsp_cfg_t                  cfg,
  input  wsp_pkg::wsp_cmd_t                  cmd_r,
  output logic [wsp_pkg::DUTY_W-1:0]         duty_r,
  output logic                               reverse_r,
  output logic                               updated_r,
  output logic signed [wsp_pkg::COUNT_W-1:0] delta_r,
  output logic signed [wsp_pkg::SUM_W-1:0]   wsum_r
);

  localparam logic signed [16:0] DUTY_LIM = 17'(DUTY_MAX);

  logic signed [wsp_pkg::DRIVE_W-1:0] drive_r, drive_nxt;
  logic signed [16:0]                 diff, slew, diff_c, d, dl, lim, d_c;
  logic [wsp_pkg::DRIVE_W-1:0]        mag;

  // Slew step and drive clamp
  always_comb begin
    diff = 17'(cmd_r.cmd) - 17'(drive_r);
    slew = $signed({3'b0, cfg.slew_limit});
    if (diff > slew) begin
      diff_c = slew;
    end else if (diff < -slew) begin
      diff_c = -slew;
    end else begin
      diff_c = diff;
    end
    d   = 17'(drive_r) + diff_c;
    dl  = $signed({3'b0, cfg.drive_limit});
    lim = (dl < DUTY_LIM) ? dl : DUTY_LIM;
    if (d > lim) begin
      d_c = lim;
    end else if (d < -lim) begin
      d_c = -lim;
    end else begin
      d_c = d;
    end
    case (cmd_r.tag.op)
      wsp_pkg::OP_UPDATE: drive_nxt = wsp_pkg::DRIVE_W'(d_c);
      wsp_pkg::OP_CLEAR:  drive_nxt = '0;
      default:            drive_nxt = drive_r;
    endcase
    mag = drive_nxt[wsp_pkg::DRIVE_W-1] ? wsp_pkg::DRIVE_W'(-drive_nxt)
                                        : wsp_pkg::DRIVE_W'(drive_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
    end else if (pipe.take_d) begin
      drive_r <= drive_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (pipe.take_d) begin
      duty_r    <= mag[wsp_pkg::DUTY_W-1:0];
      reverse_r <= drive_nxt[wsp_pkg::DRIVE_W-1];
      updated_r <= cmd_r.tag.updated;
      delta_r   <= cmd_r.tag.delta;
      wsum_r    <= cmd_r.tag.wsum;
    end
  end

endmodule

@@ hdl/wheel_speed_pid_with_feedforward_top.sv @@
// Wheel speed regulator: encoder window sum, PI-D with feedforward, slew and drive limit.
// A result is valid once its item has passed the front, multiply, sum/saturate and drive
// registers in turn. Throughput: one item per cycle; a waiting
// result stalls a new transaction only once all four stages are full.
// Reset (rst_n low, synchronous): pipeline emptied, loop state cleared, registers to defaults.
// Depends on wsp_pkg, wsp_if, wsp_front, wsp_gain, wsp_drive.
module wheel_speed_pid_with_feedforward_top #(
  parameter int WINDOW_SAMPLES = 10,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int DUTY_MAX       = 10000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wsp_in_if.sink                             in_ch,
  wsp_out_if.source                          out_ch,
  input  logic                               cfg_wr_en,
  input  logic [wsp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  wsp_pkg::wsp_cfg_t   cfg_r;
  wsp_pkg::wsp_pipe_t  pipe;
  wsp_pkg::wsp_front_t front_r;
  wsp_pkg::wsp_cmd_t   cmd_r;

  logic v1_r, v2_r, v3_r, vo_r;
  logic en1, en2, en3, en_o;
  logic in_take, out_take;
  logic [2:0] occ;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= 16'd256;
      cfg_r.integ_gain   <= '0;
      cfg_r.deriv_gain   <= '0;
      cfg_r.ff_gain      <= '0;
      cfg_r.integ_window <= 16'd100;
      cfg_r.integ_limit  <= 20'd10000;
      cfg_r.slew_limit   <= 14'd500;
      cfg_r.drive_limit  <= 14'd8000;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        wsp_pkg::REG_PROP_GAIN:   cfg_r.prop_gain    <= cfg_wdata[wsp_pkg::GAIN_W-1:0];
        wsp_pkg::REG_INTEG_GAIN:  cfg_r.integ_gain   <= cfg_wdata[wsp_pkg::GAIN_W-1:0];
        wsp_pkg::REG_DERIV_GAIN:  cfg_r.deriv_gain   <= cfg_wdata[wsp_pkg::GAIN_W-1:0];
        wsp_pkg::REG_FF_GAIN:     cfg_r.ff_gain      <= cfg_wdata[wsp_pkg::GAIN_W-1:0];
        wsp_pkg::REG_INTEG_WIN:   cfg_r.integ_window <= cfg_wdata[wsp_pkg::GAIN_W-1:0];
        wsp_pkg::REG_INTEG_LIMIT: cfg_r.integ_limit  <= cfg_wdata[wsp_pkg::LIMIT_W-1:0];
        wsp_pkg::REG_SLEW_LIMIT:  cfg_r.slew_limit   <= cfg_wdata[wsp_pkg::DRV_CFG_W-1:0];
        wsp_pkg::REG_DRIVE_LIMIT: cfg_r.drive_limit  <= cfg_wdata[wsp_pkg::DRV_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage loads when it is empty or its contents move on
  always_comb begin
    en_o        = !vo_r || out_ch.ready;
    en3         = !v3_r || en_o;
    en2         = !v2_r || en3;
    en1         = !v1_r || en2;
    in_take     = in_ch.valid && en1;
    out_take    = vo_r && out_ch.ready;
    pipe.take_a = in_take;
    pipe.take_b = v1_r && en2;
    pipe.take_c = v2_r && en3;
    pipe.take_d = v3_r && en_o;
    occ         = {2'b0, v1_r} + {2'b0, v2_r} + {2'b0, v3_r} + {2'b0, vo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1)  v1_r <= in_ch.valid;
      if (en2)  v2_r <= v1_r;
      if (en3)  v3_r <= v2_r;
      if (en_o) vo_r <= v3_r;
    end
  end

  assign in_ch.ready  = en1;
  assign out_ch.valid = vo_r;

  wsp_front #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (pipe.take_a),
    .kind          (in_ch.kind),
    .encoder_count (in_ch.encoder_count),
    .target_value  (in_ch.target_value),
    .cfg           (cfg_r),
    .front_r       (front_r)
  );

  wsp_gain #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_gain (
    .clk     (clk),
    .pipe    (pipe),
    .cfg     (cfg_r),
    .front_r (front_r),
    .cmd_r   (cmd_r)
  );

  wsp_drive #(
    .DUTY_MAX (DUTY_MAX)
  ) u_drive (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe      (pipe),
    .cfg       (cfg_r),
    .cmd_r     (cmd_r),
    .duty_r    (out_ch.drive_duty),
    .reverse_r (out_ch.drive_reverse),
    .updated_r (out_ch.drive_updated),
    .delta_r   (out_ch.sample_delta),
    .wsum_r    (out_ch.window_pulses)
  );

  // Checks
  // ready only drops when the front stage is holding an item
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v1_r)
    else $error("input stalled with empty front stage");

  // an accepted transaction with nothing leaving grows the occupancy by one
  a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !out_take) |=> (occ == $past(occ) + 3'd1))
    else $error("pipeline lost or duplicated a transaction");

  // a transaction leaving with nothing entering shrinks it by one
  a_occ_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !in_take) |=> (occ == $past(occ) - 3'd1))
    else $error("pipeline occupancy wrong after result taken");

  // drive magnitude never passes the duty ceiling
  a_duty_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({2'b0, out_ch.drive_duty} <= 16'(DUTY_MAX)))
    else $error("drive duty above ceiling");

endmodule
